// ----- hw/rtl/cfpr_pkg.sv -----
// Shared types, constants and CRC/kind functions for the framed packet receiver.
// Used by every module under hw/rtl; depends on nothing else.
package cfpr_pkg;

	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 16;

	localparam logic [CfgIndexW-1:0] REG_SYNC_BYTE  = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_CRC8_POLY  = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_CRC8_INIT  = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_CRC16_POLY = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_CRC16_INIT = 3'd4;

	localparam logic [7:0]  SYNC_RESET       = 8'h3D;
	localparam logic [7:0]  CRC8_POLY_RESET  = 8'h39;
	localparam logic [7:0]  CRC8_INIT_RESET  = 8'h66;
	localparam logic [15:0] CRC16_POLY_RESET = 16'h1021;
	localparam logic [15:0] CRC16_INIT_RESET = 16'h913D;

	localparam logic [7:0] DEFAULT_LEN = 8'd6;
	localparam logic [7:0] CMD_HEAD    = 8'hC5;
	localparam logic [7:0] SUB_HEAD    = 8'h12;

	localparam logic [3:0] KIND_CMD_03   = 4'd0;
	localparam logic [3:0] KIND_CMD_04   = 4'd1;
	localparam logic [3:0] KIND_CMD_05   = 4'd2;
	localparam logic [3:0] KIND_CMD_06   = 4'd3;
	localparam logic [3:0] KIND_CMD_07   = 4'd4;
	localparam logic [3:0] KIND_CMD_08   = 4'd5;
	localparam logic [3:0] KIND_CMD_20   = 4'd6;
	localparam logic [3:0] KIND_SUB_03   = 4'd7;
	localparam logic [3:0] KIND_SUB_06   = 4'd8;
	localparam logic [3:0] KIND_SUB_09   = 4'd9;
	localparam logic [3:0] KIND_OTHER    = 4'd10;
	localparam logic [3:0] KIND_CRC_FAIL = 4'd11;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [7:0]  crc8_poly;
		logic [7:0]  crc8_init;
		logic [15:0] crc16_poly;
		logic [15:0] crc16_init;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] position;
		logic       frame_end;
		logic       aborted;
		logic [7:0] frame_length;
		logic       crc_ok;
		logic [3:0] kind;
	} result_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] v;
		v = c ^ b;
		for (int i = 0; i < 8; i++) begin
			v = v[7] ? ({v[6:0], 1'b0} ^ poly) : {v[6:0], 1'b0};
		end
		return v;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b,
		input logic [15:0] poly);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			v = v[15] ? ({v[14:0], 1'b0} ^ poly) : {v[14:0], 1'b0};
		end
		return v;
	endfunction

	// Captured bytes are those at positions 1, 4, 8 and 10 of the frame.
	function automatic logic [3:0] kind_of(input logic [3:0][7:0] cap, input logic [3:0] cv);
		logic [3:0] k;
		k = KIND_OTHER;
		if (cv[0] && cap[0] == CMD_HEAD) begin
			if (cv[1]) begin
				case (cap[1])
					8'h03: k = KIND_CMD_03;
					8'h04: k = KIND_CMD_04;
					8'h05: k = KIND_CMD_05;
					8'h06: k = KIND_CMD_06;
					8'h07: k = KIND_CMD_07;
					8'h08: k = KIND_CMD_08;
					8'h20: k = KIND_CMD_20;
					default: k = KIND_OTHER;
				endcase
			end
		end else if (cv[2] && cap[2] == SUB_HEAD && cv[3]) begin
			case (cap[3])
				8'h03: k = KIND_SUB_03;
				8'h06: k = KIND_SUB_06;
				8'h09: k = KIND_SUB_09;
				default: k = KIND_OTHER;
			endcase
		end
		return k;
	endfunction

endpackage

// ----- hw/rtl/cfpr_cfg_regs.sv -----
// Configuration register bank of the framed packet receiver.
// Depends on cfpr_pkg for the register indexes, reset values and cfg_t.
module cfpr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cfpr_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [cfpr_pkg::CfgDataW-1:0]  cfg_data,
	output cfpr_pkg::cfg_t                 cfg
);

	cfpr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte  <= cfpr_pkg::SYNC_RESET;
			cfg_q.crc8_poly  <= cfpr_pkg::CRC8_POLY_RESET;
			cfg_q.crc8_init  <= cfpr_pkg::CRC8_INIT_RESET;
			cfg_q.crc16_poly <= cfpr_pkg::CRC16_POLY_RESET;
			cfg_q.crc16_init <= cfpr_pkg::CRC16_INIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cfpr_pkg::REG_SYNC_BYTE:  cfg_q.sync_byte  <= cfg_data[7:0];
				cfpr_pkg::REG_CRC8_POLY:  cfg_q.crc8_poly  <= cfg_data[7:0];
				cfpr_pkg::REG_CRC8_INIT:  cfg_q.crc8_init  <= cfg_data[7:0];
				cfpr_pkg::REG_CRC16_POLY: cfg_q.crc16_poly <= cfg_data;
				cfpr_pkg::REG_CRC16_INIT: cfg_q.crc16_init <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/cfpr_frame_engine.sv -----
// Frame state and per-byte decode: header CRC8, frame CRC16, length and kind.
// Depends on cfpr_pkg for cfg_t, result_t and the CRC and kind functions.
module cfpr_frame_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  cfpr_pkg::cfg_t      cfg,
	input  logic                step_en,
	input  logic [7:0]          b,
	output logic                has_result,
	output cfpr_pkg::result_t   res
);

	logic [7:0]      byte_count_q;
	logic            short_q;
	logic [7:0]      flen_q;
	logic [7:0]      hcrc_q;
	logic [15:0]     fcrc_q;
	logic [7:0]      held0_q;
	logic [7:0]      held1_q;
	logic [3:0][7:0] cap_q;
	logic [3:0]      capv_q;
	logic [7:0]      sync_seen_q;

	logic [7:0]      p;
	logic            short_n;
	logic [7:0]      len_pos;
	logic [7:0]      crc_pos;
	logic [7:0]      flen_n;
	logic [3:0][7:0] cap_n;
	logic [3:0]      capv_n;
	logic [7:0]      hcrc_n;
	logic            abort;
	logic [15:0]     fed;
	logic [15:0]     init_fed;
	logic [8:0]      cnt;
	logic            frame_done;
	logic            ok;
	logic            is_sync;

	assign p        = byte_count_q;
	assign is_sync  = (p == 8'd0) && (b == cfg.sync_byte);
	assign short_n  = (p == 8'd1) ? b[7] : short_q;
	assign len_pos  = short_n ? 8'd2 : 8'd4;
	assign crc_pos  = short_n ? 8'd3 : 8'd6;
	assign flen_n   = (p == len_pos) ? b : flen_q;
	assign hcrc_n   = cfpr_pkg::crc8_step(hcrc_q, b, cfg.crc8_poly);
	assign abort    = (p == crc_pos) && (b != hcrc_q);
	assign fed      = (p >= 8'd2) ? cfpr_pkg::crc16_step(fcrc_q, held0_q, cfg.crc16_poly)
		: fcrc_q;
	assign init_fed = cfpr_pkg::crc16_step(cfg.crc16_init, sync_seen_q, cfg.crc16_poly);
	assign cnt      = {1'b0, p} + 9'd1;
	assign frame_done = !abort && (cnt >= {1'b0, flen_n});

	always_comb begin
		cap_n  = cap_q;
		capv_n = capv_q;
		case (p)
			8'd1:  begin cap_n[0] = b; capv_n[0] = 1'b1; end
			8'd4:  begin cap_n[1] = b; capv_n[1] = 1'b1; end
			8'd8:  begin cap_n[2] = b; capv_n[2] = 1'b1; end
			8'd10: begin cap_n[3] = b; capv_n[3] = 1'b1; end
			default: ;
		endcase
	end

	// A length byte smaller than its own place ends the frame early, so the
	// trailing check bytes then come from older bytes of the frame.
	always_comb begin
		if (flen_n < 8'd2) begin
			ok = 1'b0;
		end else if ({1'b0, flen_n} == cnt) begin
			ok = (fed[7:0] == held1_q) && (fed[15:8] == b);
		end else if (flen_n == p) begin
			ok = (fcrc_q[7:0] == held0_q) && (fcrc_q[15:8] == held1_q);
		end else if (flen_n == 8'd2) begin
			ok = (cfg.crc16_init[7:0] == sync_seen_q) && (cfg.crc16_init[15:8] == cap_n[0]);
		end else begin
			ok = (init_fed[7:0] == cap_n[0]) && (init_fed[15:8] == held0_q);
		end
	end

	always_comb begin
		res = '0;
		res.data_byte = b;
		if (p == 8'd0) begin
			has_result = is_sync;
		end else begin
			has_result   = 1'b1;
			res.position = p;
			res.aborted  = abort;
			if (frame_done) begin
				res.frame_end    = 1'b1;
				res.frame_length = flen_n;
				res.crc_ok       = ok;
				res.kind         = ok ? cfpr_pkg::kind_of(cap_n, capv_n)
					: cfpr_pkg::KIND_CRC_FAIL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			short_q      <= 1'b0;
			flen_q       <= cfpr_pkg::DEFAULT_LEN;
			hcrc_q       <= '0;
			fcrc_q       <= '0;
			held0_q      <= '0;
			held1_q      <= '0;
			cap_q        <= '0;
			capv_q       <= '0;
			sync_seen_q  <= '0;
		end else if (step_en) begin
			if (p == 8'd0) begin
				if (is_sync) begin
					byte_count_q <= 8'd1;
					short_q      <= 1'b0;
					flen_q       <= cfpr_pkg::DEFAULT_LEN;
					hcrc_q       <= cfpr_pkg::crc8_step(cfg.crc8_init, b, cfg.crc8_poly);
					fcrc_q       <= cfg.crc16_init;
					held0_q      <= '0;
					held1_q      <= b;
					capv_q       <= '0;
					sync_seen_q  <= b;
				end
			end else begin
				short_q <= short_n;
				flen_q  <= flen_n;
				cap_q   <= cap_n;
				capv_q  <= capv_n;
				if (p < crc_pos) begin
					hcrc_q <= hcrc_n;
				end
				if (abort || frame_done) begin
					byte_count_q <= '0;
				end else begin
					byte_count_q <= cnt[7:0];
					fcrc_q       <= fed;
					held0_q      <= held1_q;
					held1_q      <= b;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/crc_framed_packet_receiver_core.sv -----
// Top level of the framed packet receiver: input register, frame engine and result register.
// Depends on cfpr_pkg, cfpr_cfg_regs and cfpr_frame_engine.
//
// The receiver takes one byte per clock cycle while in_stall is low. An accepted byte passes
// through the input register, where the byte-wide CRC8 and CRC16 updates and the frame decode
// run as combinational logic, and then the result register, which holds its result item.
// A byte that arrives while no frame is open and is not the sync byte gives no item; every
// other byte gives exactly one, echoed with its position. Input stall rises only while the
// result register is full and stalled.
module crc_framed_packet_receiver_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [cfpr_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [cfpr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     data_byte,
	output logic [7:0]                     position,
	output logic                           frame_end,
	output logic                           aborted,
	output logic [7:0]                     frame_length,
	output logic                           crc_ok,
	output logic [3:0]                     kind
);

	cfpr_pkg::cfg_t    cfg;
	cfpr_pkg::result_t res;
	cfpr_pkg::result_t res_q;
	logic              has_result;
	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              out_valid_q;
	logic              out_free;
	logic              advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	cfpr_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfpr_frame_engine u_frame_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_en    (advance),
		.b          (rx_byte_s1),
		.has_result (has_result),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = res_q.data_byte;
	assign position     = res_q.position;
	assign frame_end    = res_q.frame_end;
	assign aborted      = res_q.aborted;
	assign frame_length = res_q.frame_length;
	assign crc_ok       = res_q.crc_ok;
	assign kind         = res_q.kind;

endmodule

// ----- tb/tb_crc_framed_packet_receiver_core.sv -----
// Self-checking bench for crc_framed_packet_receiver_core: random and directed byte streams,
// per-byte echo prediction, header CRC8 and frame CRC16 checks, several register settings.
// Depends on cfpr_pkg and the receiver RTL only.
module tb_crc_framed_packet_receiver_core;
	timeunit 1ns;
	timeprecision 1ps;

	import cfpr_pkg::*;

	localparam logic [7:0] CMD_CODES [7] = '{8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h20};
	localparam logic [7:0] SUB_CODES [3] = '{8'h03, 8'h06, 8'h09};
	localparam int PHASE_BYTES = 225;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           data_byte;
	logic [7:0]           position;
	logic                 frame_end;
	logic                 aborted;
	logic [7:0]           frame_length;
	logic                 crc_ok;
	logic [3:0]           kind;

	crc_framed_packet_receiver_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.position     (position),
		.frame_end    (frame_end),
		.aborted      (aborted),
		.frame_length (frame_length),
		.crc_ok       (crc_ok),
		.kind         (kind)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	cfg_t       settings = {SYNC_RESET, CRC8_POLY_RESET, CRC8_INIT_RESET,
		CRC16_POLY_RESET, CRC16_INIT_RESET};
	logic [7:0] frame_pos = 8'd0;
	logic       hdr_short = 1'b0;
	logic [7:0] flen_value = DEFAULT_LEN;
	logic [7:0] hdr_crc = 8'h00;
	logic [15:0] run_crc = 16'h0000;
	logic [7:0] recent [2] = '{8'h00, 8'h00};
	logic [7:0] cap [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
	logic [3:0] cap_valid = 4'h0;
	logic [7:0] sync_val = 8'h00;

	logic [7:0] tx_bytes [$];
	result_t    predicted_echoes [$];
	result_t    echo_want;
	int         error_count = 0;
	int         gap_pct = 0;
	int         stall_pct = 0;

	function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			r = (r[7] ^ b[i]) ? ({r[6:0], 1'b0} ^ settings.crc8_poly) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			r = (r[15] ^ b[i]) ? ({r[14:0], 1'b0} ^ settings.crc16_poly) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [3:0] classify();
		logic [3:0] k;
		k = KIND_OTHER;
		if (cap_valid[0] && cap[0] == CMD_HEAD) begin
			if (cap_valid[1]) begin
				for (int i = 0; i < 7; i++) begin
					if (cap[1] == CMD_CODES[i]) k = KIND_CMD_03 + 4'(i);
				end
			end
		end else if (cap_valid[2] && cap_valid[3] && cap[2] == SUB_HEAD) begin
			for (int i = 0; i < 3; i++) begin
				if (cap[3] == SUB_CODES[i]) k = KIND_SUB_03 + 4'(i);
			end
		end
		return k;
	endfunction

	task automatic predict_echo(input logic [7:0] b);
		result_t     echo;
		logic [7:0]  p;
		logic [7:0]  len_at;
		logic [7:0]  crc_at;
		logic [15:0] fed;
		logic [15:0] c16;
		int          cnt;
		logic        ok;
		echo = '0;
		echo.data_byte = b;
		p = frame_pos;
		if (p == 8'd0) begin
			if (b != settings.sync_byte) return;
			frame_pos = 8'd1;
			hdr_short = 1'b0;
			flen_value = DEFAULT_LEN;
			hdr_crc = crc8_next(settings.crc8_init, b);
			run_crc = settings.crc16_init;
			recent[0] = 8'h00;
			recent[1] = b;
			cap_valid = 4'h0;
			sync_val = b;
			predicted_echoes.push_back(echo);
			return;
		end
		echo.position = p;
		if (p == 8'd1) hdr_short = b[7];
		len_at = hdr_short ? 8'd2 : 8'd4;
		crc_at = hdr_short ? 8'd3 : 8'd6;
		case (p)
			8'd1: begin cap[0] = b; cap_valid[0] = 1'b1; end
			8'd4: begin cap[1] = b; cap_valid[1] = 1'b1; end
			8'd8: begin cap[2] = b; cap_valid[2] = 1'b1; end
			8'd10: begin cap[3] = b; cap_valid[3] = 1'b1; end
			default: ;
		endcase
		if (p == len_at) flen_value = b;
		if (p < crc_at) begin
			hdr_crc = crc8_next(hdr_crc, b);
		end else if (p == crc_at && b != hdr_crc) begin
			frame_pos = 8'd0;
			echo.aborted = 1'b1;
			predicted_echoes.push_back(echo);
			return;
		end
		fed = (p >= 8'd2) ? crc16_next(run_crc, recent[0]) : run_crc;
		cnt = int'(p) + 1;
		if (cnt >= int'(flen_value)) begin
			if (flen_value < 8'd2) begin
				ok = 1'b0;
			end else if (int'(flen_value) == cnt) begin
				ok = (fed == {b, recent[1]});
			end else if (flen_value == p) begin
				ok = (run_crc == {recent[1], recent[0]});
			end else if (flen_value == 8'd2) begin
				ok = (settings.crc16_init == {cap[0], sync_val});
			end else begin
				c16 = crc16_next(settings.crc16_init, sync_val);
				ok = (c16 == {recent[0], cap[0]});
			end
			echo.frame_end = 1'b1;
			echo.frame_length = flen_value;
			echo.crc_ok = ok;
			echo.kind = ok ? classify() : KIND_CRC_FAIL;
			frame_pos = 8'd0;
			predicted_echoes.push_back(echo);
			return;
		end
		run_crc = fed;
		recent[0] = recent[1];
		recent[1] = b;
		frame_pos = cnt[7:0];
		predicted_echoes.push_back(echo);
	endtask

	task automatic report_error(input string msg);
		error_count++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) report_error($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_echo(rx_byte);
			if (!in_valid || !in_stall) begin
				if (tx_bytes.size() > 0 && $urandom_range(99) >= gap_pct) begin
					in_valid <= 1'b1;
					rx_byte <= tx_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (predicted_echoes.size() == 0) begin
					report_error($sformatf("unexpected item, byte %02h at position %0d",
						data_byte, position));
				end else begin
					echo_want = predicted_echoes.pop_front();
					check_field("data_byte", data_byte, echo_want.data_byte);
					check_field("position", position, echo_want.position);
					check_field("frame_end", frame_end, echo_want.frame_end);
					check_field("aborted", aborted, echo_want.aborted);
					check_field("frame_length", frame_length, echo_want.frame_length);
					check_field("crc_ok", crc_ok, echo_want.crc_ok);
					check_field("kind", kind, echo_want.kind);
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SYNC_BYTE: settings.sync_byte = val[7:0];
			REG_CRC8_POLY: settings.crc8_poly = val[7:0];
			REG_CRC8_INIT: settings.crc8_init = val[7:0];
			REG_CRC16_POLY: settings.crc16_poly = val;
			REG_CRC16_INIT: settings.crc16_init = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int choice);
		cfg_t s;
		case (choice)
			1: s = '0;
			2: s = '1;
			default: s = 56'({$urandom(), $urandom()});
		endcase
		write_reg(REG_SYNC_BYTE, {8'($urandom), s.sync_byte});
		write_reg(REG_CRC8_POLY, {8'($urandom), s.crc8_poly});
		write_reg(REG_CRC8_INIT, {8'($urandom), s.crc8_init});
		write_reg(REG_CRC16_POLY, s.crc16_poly);
		write_reg(REG_CRC16_INIT, s.crc16_init);
		write_reg(REG_CRC16_INIT + 3'd1 + 3'($urandom_range(2)), 16'($urandom));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tx_bytes.size() != 0 || in_valid || predicted_echoes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int queue_frame(input bit broken);
		logic [7:0]  frame [256];
		int          len;
		int          n;
		int          len_at;
		int          crc_at;
		int          style;
		int          sel;
		int          pos;
		bit          is_short;
		logic [7:0]  c8;
		logic [15:0] c16;
		style = $urandom_range(2);
		is_short = (style == 1) ? 1'b1 : 1'($urandom_range(1));
		len_at = is_short ? 2 : 4;
		crc_at = is_short ? 3 : 6;
		sel = $urandom_range(99);
		if (sel < 12) len = $urandom_range(crc_at + 2, 0);
		else if (sel < 15) len = $urandom_range(255, 25);
		else len = $urandom_range(24, crc_at + 3);
		n = (len > len_at + 1) ? len : len_at + 1;
		for (int i = 0; i < n; i++) frame[i] = 8'($urandom);
		frame[0] = settings.sync_byte;
		frame[1][7] = is_short;
		if (style == 1) begin
			frame[1] = CMD_HEAD;
			if (n > 4 && $urandom_range(3) != 0) frame[4] = CMD_CODES[$urandom_range(6)];
		end else if (style == 2) begin
			if (frame[1] == CMD_HEAD) frame[1][0] = 1'b0;
			if (n > 8 && $urandom_range(3) != 0) frame[8] = SUB_HEAD;
			if (n > 10 && $urandom_range(3) != 0) frame[10] = SUB_CODES[$urandom_range(2)];
		end
		frame[len_at] = 8'(len);
		if (crc_at < n) begin
			c8 = settings.crc8_init;
			for (int i = 0; i < crc_at; i++) c8 = crc8_next(c8, frame[i]);
			frame[crc_at] = c8;
		end
		if (len == n && len >= crc_at + 3) begin
			c16 = settings.crc16_init;
			for (int i = 0; i < len - 2; i++) c16 = crc16_next(c16, frame[i]);
			frame[len - 2] = c16[7:0];
			frame[len - 1] = c16[15:8];
		end
		if (broken) begin
			pos = $urandom_range(n - 1, 1);
			frame[pos] ^= 8'($urandom_range(255, 1));
		end
		for (int i = 0; i < n; i++) tx_bytes.push_back(frame[i]);
		return n;
	endfunction

	initial begin
		logic [7:0]  d [8];
		logic [7:0]  c8;
		logic [15:0] c16;
		logic [7:0]  nb;
		int          made;
		int          sel;

		// Directed bytes under the reset settings: stray bytes while idle, lengths of zero
		// and one, a header check failure, a long header of length two, a good command frame.
		tx_bytes = {8'h00, 8'hFF, SYNC_RESET, 8'h80, 8'h00, SYNC_RESET, 8'hFF, 8'h01};
		c8 = crc8_next(crc8_next(crc8_next(CRC8_INIT_RESET, SYNC_RESET), 8'h81), 8'h09);
		tx_bytes = {tx_bytes, SYNC_RESET, 8'h81, 8'h09, c8 ^ 8'h01,
			SYNC_RESET, 8'h00, 8'h7F, 8'h55, 8'h02};
		d = '{SYNC_RESET, CMD_HEAD, 8'h08, 8'h00, CMD_CODES[3], 8'hA5, 8'h00, 8'h00};
		c8 = CRC8_INIT_RESET;
		for (int i = 0; i < 3; i++) c8 = crc8_next(c8, d[i]);
		d[3] = c8;
		c16 = CRC16_INIT_RESET;
		for (int i = 0; i < 6; i++) c16 = crc16_next(c16, d[i]);
		d[6] = c16[7:0];
		d[7] = c16[15:8];
		foreach (d[i]) tx_bytes.push_back(d[i]);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				wait_drained();
				apply_settings(ph);
			end
			gap_pct = (ph < 2) ? 9 : (ph < 4) ? 54 : 0;
			stall_pct = (ph < 2) ? 54 : (ph < 4) ? 9 : 0;
			made = 0;
			while (made < PHASE_BYTES) begin
				sel = $urandom_range(99);
				if (sel < 8) begin
					repeat ($urandom_range(4, 1)) begin
						nb = 8'($urandom);
						if (nb == settings.sync_byte) nb ^= 8'h01;
						tx_bytes.push_back(nb);
					end
				end else begin
					made += queue_frame(sel < 20);
				end
			end
		end
		wait_drained();

		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
